// File: rtl/core/fen_position_parser_assert.svh
// assertion helpers shared by the parser modules
// each macro expects clk and arst_n in the enclosing scope
`ifndef FEN_POSITION_PARSER_ASSERT_SVH
`define FEN_POSITION_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FPP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FPP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fpp_pkg.sv
package fpp_pkg;

	localparam int NUM_KINDS  = 6;
	localparam int NUM_BOARDS = 12;

	// ascii codes
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_1       = 8'h31;
	localparam logic [7:0] CH_8       = 8'h38;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_K    = 8'h4B;
	localparam logic [7:0] CH_UP_Q    = 8'h51;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_B    = 8'h62;
	localparam logic [7:0] CH_LO_H    = 8'h68;
	localparam logic [7:0] CH_LO_K    = 8'h6B;
	localparam logic [7:0] CH_LO_N    = 8'h6E;
	localparam logic [7:0] CH_LO_P    = 8'h70;
	localparam logic [7:0] CH_LO_Q    = 8'h71;
	localparam logic [7:0] CH_LO_R    = 8'h72;
	localparam logic [7:0] CH_LO_W    = 8'h77;
	localparam logic [7:0] CASE_GAP   = 8'h20;

	// castling right bits
	localparam logic [3:0] CASTLE_WK = 4'b0001;
	localparam logic [3:0] CASTLE_WQ = 4'b0010;
	localparam logic [3:0] CASTLE_BK = 4'b0100;
	localparam logic [3:0] CASTLE_BQ = 4'b1000;

	// piece kinds
	localparam logic [2:0] KIND_PAWN   = 3'd0;
	localparam logic [2:0] KIND_KNIGHT = 3'd1;
	localparam logic [2:0] KIND_BISHOP = 3'd2;
	localparam logic [2:0] KIND_ROOK   = 3'd3;
	localparam logic [2:0] KIND_QUEEN  = 3'd4;
	localparam logic [2:0] KIND_KING   = 3'd5;

	// en-passant progress
	localparam logic [1:0] EP_NONE   = 2'd0;
	localparam logic [1:0] EP_FILE   = 2'd1;
	localparam logic [1:0] EP_DONE   = 2'd2;
	localparam logic [1:0] EP_CLOSED = 2'd3;

	typedef enum logic [1:0] {
		SEC_PLACE,
		SEC_SIDE,
		SEC_CASTLE,
		SEC_PASSANT
	} section_e_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SLASH,
		OP_SKIP,
		OP_PIECE,
		OP_SIDE,
		OP_CASTLE,
		OP_EP,
		OP_EP_CLOSE
	} op_code_t;

	// classified character handed from front to back
	typedef struct packed {
		op_code_t   code;
		logic [7:0] arg;
		logic       last;
	} op_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic        piece_color;
		logic [2:0]  piece_kind;
		logic [63:0] piece_board;
		logic        white_to_move;
		logic [3:0]  castle_rights;
		logic        passant_valid;
		logic [5:0]  passant_square;
		logic [63:0] white_occupancy;
		logic [63:0] black_occupancy;
		logic [63:0] total_occupancy;
		logic        final_board;
	} result_t;

endpackage

// File: rtl/core/fpp_front.sv
module fpp_front import fpp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	output logic  op_push,
	output op_t   op
);

	section_e_t section_q, section_d;
	logic [7:0] ch;
	logic [7:0] lower;
	logic       upper;
	logic       kind_ok;
	logic [2:0] kind;

	assign ch      = item.char_code;
	assign op_push = accept;

	always_comb begin
		upper   = ch inside {[CH_UP_A:CH_UP_Z]};
		lower   = upper ? ch + CASE_GAP : ch;
		kind_ok = 1'b1;
		case (lower)
			CH_LO_P: kind = KIND_PAWN;
			CH_LO_N: kind = KIND_KNIGHT;
			CH_LO_B: kind = KIND_BISHOP;
			CH_LO_R: kind = KIND_ROOK;
			CH_LO_Q: kind = KIND_QUEEN;
			CH_LO_K: kind = KIND_KING;
			default: begin
				kind    = KIND_PAWN;
				kind_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		section_d = section_q;
		op.code   = OP_NONE;
		op.arg    = '0;
		op.last   = item.last_char;
		if (ch == CH_SPACE) begin
			if (section_q != SEC_PASSANT) begin
				section_d = section_e_t'(section_q + 2'd1);
			end else begin
				op.code = OP_EP_CLOSE;
			end
		end else begin
			case (section_q)
				SEC_PLACE: begin
					if (ch == CH_SLASH) begin
						op.code = OP_SLASH;
					end else if (ch inside {[CH_0:CH_9]}) begin
						op.code = OP_SKIP;
						op.arg  = ch - CH_0;
					end else if (kind_ok) begin
						op.code = OP_PIECE;
						// white boards first, then black
						op.arg  = upper ? {5'd0, kind} : {5'd0, kind} + 8'(NUM_KINDS);
					end
				end
				SEC_SIDE: begin
					op.code = OP_SIDE;
					op.arg  = {7'd0, ch == CH_LO_W};
				end
				SEC_CASTLE: begin
					op.code = OP_CASTLE;
					case (ch)
						CH_UP_K: op.arg = {4'd0, CASTLE_WK};
						CH_UP_Q: op.arg = {4'd0, CASTLE_WQ};
						CH_LO_K: op.arg = {4'd0, CASTLE_BK};
						CH_LO_Q: op.arg = {4'd0, CASTLE_BQ};
						default: op.arg = '0;
					endcase
				end
				SEC_PASSANT: begin
					op.code = OP_EP;
					op.arg  = ch;
				end
				default: op.code = OP_NONE;
			endcase
		end
		if (item.last_char) begin
			section_d = SEC_PLACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q <= SEC_PLACE;
		end else if (accept) begin
			section_q <= section_d;
		end
	end

endmodule

// File: rtl/core/fpp_fifo.sv
module fpp_fifo import fpp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_op,
	output logic full,
	input  logic rd_en,
	output op_t  rd_op,
	output logic avail
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign avail = count_q != '0;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(wr_en) - CW'(rd_en);
		end
	end

`include "fen_position_parser_assert.svh"

	`FPP_ASSERT_NOW(a_no_read_empty, rd_en, avail, "queue read while empty")
	`FPP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count overflow")

endmodule

// File: rtl/core/fpp_back.sv
module fpp_back import fpp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  op_t     op,
	input  logic    op_avail,
	output logic    op_take,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	// live position state
	logic [3:0]  rank_q, rank_d;
	logic [3:0]  file_q, file_d;
	logic [63:0] boards_q [NUM_BOARDS];
	logic [63:0] boards_d [NUM_BOARDS];
	logic [63:0] wocc_q, wocc_d;
	logic [63:0] bocc_q, bocc_d;
	logic        side_q, side_d;
	logic        side_seen_q, side_seen_d;
	logic [3:0]  castle_q, castle_d;
	logic [1:0]  ep_seen_q, ep_seen_d;
	logic [7:0]  ep_file_q, ep_file_d;
	logic [6:0]  ep_res_q, ep_res_d;

	// snapshot bank drained one board per cycle while the output register is free or popped
	logic [63:0] bank_board_q [NUM_BOARDS];
	logic [63:0] bank_wocc_q;
	logic [63:0] bank_bocc_q;
	logic        bank_side_q;
	logic [3:0]  bank_castle_q;
	logic [6:0]  bank_ep_q;
	logic        bank_valid_q;
	logic [3:0]  idx_q;

	result_t     out_q;
	logic        out_valid_q;

	logic [4:0]  fsum;
	logic [63:0] sq_bit;
	logic        on_board;
	logic [7:0]  ep_file_off;
	logic [7:0]  ep_rank_off;
	logic        load;
	logic [3:0]  kind_full;

	assign op_take = op_avail && (!op.last || !bank_valid_q);
	assign load    = bank_valid_q && (!out_valid_q || pop);
	assign empty   = !out_valid_q;
	assign result  = out_q;

	assign on_board    = !rank_q[3] && !file_q[3];
	assign sq_bit      = 64'd1 << {rank_q[2:0], file_q[2:0]};
	assign fsum        = {1'b0, file_q} + {1'b0, op.arg[3:0]};
	assign ep_file_off = ep_file_q - CH_LO_A;
	assign ep_rank_off = op.arg - CH_1;
	assign kind_full   = (idx_q >= 4'(NUM_KINDS)) ? idx_q - 4'(NUM_KINDS) : idx_q;

	always_comb begin
		rank_d      = rank_q;
		file_d      = file_q;
		boards_d    = boards_q;
		wocc_d      = wocc_q;
		bocc_d      = bocc_q;
		side_d      = side_q;
		side_seen_d = side_seen_q;
		castle_d    = castle_q;
		ep_seen_d   = ep_seen_q;
		ep_file_d   = ep_file_q;
		ep_res_d    = ep_res_q;
		case (op.code)
			OP_SLASH: begin
				rank_d = (rank_q == 4'd0 || rank_q > 4'd7) ? 4'd15 : rank_q - 4'd1;
				file_d = 4'd0;
			end
			OP_SKIP: begin
				file_d = (fsum > 5'd15) ? 4'd15 : fsum[3:0];
			end
			OP_PIECE: begin
				if (on_board) begin
					for (int i = 0; i < NUM_BOARDS; i++) begin
						if (op.arg[3:0] == 4'(i)) begin
							boards_d[i] = boards_q[i] | sq_bit;
						end
					end
					if (op.arg[3:0] < 4'(NUM_KINDS)) begin
						wocc_d = wocc_q | sq_bit;
					end else begin
						bocc_d = bocc_q | sq_bit;
					end
				end
				if (file_q != 4'd15) begin
					file_d = file_q + 4'd1;
				end
			end
			OP_SIDE: begin
				if (!side_seen_q) begin
					side_d      = op.arg[0];
					side_seen_d = 1'b1;
				end
			end
			OP_CASTLE: begin
				castle_d = castle_q | op.arg[3:0];
			end
			OP_EP: begin
				case (ep_seen_q)
					EP_NONE: begin
						if (op.arg == CH_DASH) begin
							ep_res_d  = '0;
							ep_seen_d = EP_CLOSED;
						end else begin
							ep_file_d = op.arg;
							ep_seen_d = EP_FILE;
						end
					end
					EP_FILE: begin
						if (ep_file_q inside {[CH_LO_A:CH_LO_H]} && op.arg inside {[CH_1:CH_8]}) begin
							ep_res_d = {1'b1, ep_rank_off[2:0], ep_file_off[2:0]};
						end
						ep_seen_d = EP_DONE;
					end
					default: ep_seen_d = ep_seen_q;
				endcase
			end
			OP_EP_CLOSE: begin
				ep_seen_d = EP_CLOSED;
			end
			default: rank_d = rank_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q      <= 4'd7;
			file_q      <= 4'd0;
			for (int i = 0; i < NUM_BOARDS; i++) begin
				boards_q[i] <= '0;
			end
			wocc_q      <= '0;
			bocc_q      <= '0;
			side_q      <= 1'b0;
			side_seen_q <= 1'b0;
			castle_q    <= '0;
			ep_seen_q   <= EP_NONE;
			ep_file_q   <= '0;
			ep_res_q    <= '0;
		end else if (op_take) begin
			if (op.last) begin
				rank_q      <= 4'd7;
				file_q      <= 4'd0;
				for (int i = 0; i < NUM_BOARDS; i++) begin
					boards_q[i] <= '0;
				end
				wocc_q      <= '0;
				bocc_q      <= '0;
				side_q      <= 1'b0;
				side_seen_q <= 1'b0;
				castle_q    <= '0;
				ep_seen_q   <= EP_NONE;
				ep_file_q   <= '0;
				ep_res_q    <= '0;
			end else begin
				rank_q      <= rank_d;
				file_q      <= file_d;
				boards_q    <= boards_d;
				wocc_q      <= wocc_d;
				bocc_q      <= bocc_d;
				side_q      <= side_d;
				side_seen_q <= side_seen_d;
				castle_q    <= castle_d;
				ep_seen_q   <= ep_seen_d;
				ep_file_q   <= ep_file_d;
				ep_res_q    <= ep_res_d;
			end
		end
	end

	// bank payload
	always_ff @(posedge clk) begin
		if (op_take && op.last) begin
			bank_board_q  <= boards_d;
			bank_wocc_q   <= wocc_d;
			bank_bocc_q   <= bocc_d;
			bank_side_q   <= side_d;
			bank_castle_q <= castle_d;
			bank_ep_q     <= ep_res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (load) begin
				if (idx_q == 4'(NUM_BOARDS - 1)) begin
					idx_q        <= '0;
					bank_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
			if (op_take && op.last) begin
				bank_valid_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.piece_color     <= idx_q >= 4'(NUM_KINDS);
			out_q.piece_kind      <= kind_full[2:0];
			out_q.piece_board     <= bank_board_q[idx_q];
			out_q.white_to_move   <= bank_side_q;
			out_q.castle_rights   <= bank_castle_q;
			out_q.passant_valid   <= bank_ep_q[6];
			out_q.passant_square  <= bank_ep_q[6] ? bank_ep_q[5:0] : 6'd0;
			out_q.white_occupancy <= bank_wocc_q;
			out_q.black_occupancy <= bank_bocc_q;
			out_q.total_occupancy <= bank_wocc_q | bank_bocc_q;
			out_q.final_board     <= idx_q == 4'(NUM_BOARDS - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

`include "fen_position_parser_assert.svh"

	`FPP_ASSERT_NOW(a_bank_free, op_take && op.last, !bank_valid_q, "bank overwritten")
	`FPP_ASSERT_NOW(a_idx_range, 1'b1, idx_q < 4'(NUM_BOARDS), "board index out of range")
	`FPP_ASSERT_NEXT(a_final_tag, load && idx_q == 4'(NUM_BOARDS - 1), out_q.final_board && !bank_valid_q, "final result not tagged")
	`FPP_ASSERT_NOW(a_idle_idx, !bank_valid_q, idx_q == 4'd0, "index not rewound")

endmodule

// File: rtl/core/fen_position_parser.sv
// fen position parser: takes a position string one character per transaction
// on the item port (push/full) and, on the character marked last_char, gives
// twelve result transactions on the result port (empty/pop), white pawn
// through white king, then black pawn through black king; each carries one
// board plus the side to move, castling rights, en-passant square and the
// occupancy unions, and the twelfth has final_board set. the front classifies
// each character against the current field (split at spaces) and drops it
// into a DEPTH-entry queue; the back applies one queued transaction per cycle to
// the position state while the result bank is free or the transaction is not
// a last character. the last character copies the finished position into a
// result bank and clears the state, so the next string is parsed while the
// bank drains one board per cycle through the output register whenever that
// register is empty or being popped. rate: one character per cycle while the
// queue has room; a last character waits in the queue until the previous
// string's bank has moved its twelfth board into the output register.
module fen_position_parser import fpp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	// character transactions
	input  logic    push,
	output logic    full,
	input  item_t   item,
	// result transactions
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic accept;
	logic op_push;
	op_t  op_in;
	op_t  op_out;
	logic op_avail;
	logic op_take;

	// a character is taken whenever the queue has room
	assign accept = push && !full;

	// field tracking and character classification
	fpp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.op_push (op_push),
		.op      (op_in)
	);

	// decouples classification from the position update
	fpp_fifo #(
		.DEPTH (DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_push),
		.wr_op  (op_in),
		.full   (full),
		.rd_en  (op_take),
		.rd_op  (op_out),
		.avail  (op_avail)
	);

	// position state, result bank and output register
	fpp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_out),
		.op_avail (op_avail),
		.op_take  (op_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
